// File: design/assert_macros.svh
// Assertion macros used by the RTL of the HSV to RGB converter (included by hsv_to_rgb.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset cycles included.
`define ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: design/hsvrgb_pkg.sv
// Widths, constants, sector codes and shared types of the HSV to RGB converter.
package hsvrgb_pkg;

   // Field widths
   localparam int HUE_W  = 15;
   localparam int PCT_W  = 14;
   localparam int CHAN_W = 8;

   // Valid input limits: 360.0 degrees in Q9.6, 100.0 percent in Q7.7
   localparam logic [HUE_W-1:0] HUE_MAX = 15'd23040;
   localparam logic [PCT_W-1:0] PCT_MAX = 14'd12800;

   // One 60-degree sector in hue units
   localparam int FRAC_W = 12;
   localparam logic [FRAC_W-1:0] SECTOR_UNITS = 12'd3840;

   // Channel weight T = 12800*3840 - s*u; full weight fits in 26 bits
   localparam int T_W = 26;
   localparam logic [T_W-1:0] T_FULL = 26'd49152000;

   // v*T, then 255*v*T >> 26, then divide by 9375 through a reciprocal
   localparam int Q_W         = PCT_W + T_W;
   localparam int QS_W        = Q_W + CHAN_W;
   localparam int SCALE_SHIFT = 26;
   localparam int Y_W         = QS_W - SCALE_SHIFT;
   localparam int RECIP_W     = 23;
   localparam logic [RECIP_W-1:0] RECIP = 23'd7330078;
   localparam int RECIP_SHIFT = 36;
   localparam int Z_W         = Y_W + RECIP_W;

   // Pipeline depth, input register to output register
   localparam int N_STAGES = 8;

   // Hue sectors
   localparam int SEC_W = 3;
   localparam logic [SEC_W-1:0] SEC_RY = 3'd0;
   localparam logic [SEC_W-1:0] SEC_YG = 3'd1;
   localparam logic [SEC_W-1:0] SEC_GC = 3'd2;
   localparam logic [SEC_W-1:0] SEC_CB = 3'd3;
   localparam logic [SEC_W-1:0] SEC_BM = 3'd4;
   localparam logic [SEC_W-1:0] SEC_MR = 3'd5;

   // Stage advance strobes of the channel scaler
   typedef struct packed {
      logic mul;
      logic scale;
      logic recip;
   } hsvrgb_adv_type;

endpackage

// File: design/hsvrgb_if.sv
// Request and response channel interfaces of the HSV to RGB converter.
interface hsvrgb_req_if import hsvrgb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [HUE_W-1:0]  hue;
   logic [PCT_W-1:0]  saturation;
   logic [PCT_W-1:0]  brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   output ready);
endinterface

interface hsvrgb_rsp_if import hsvrgb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;
   logic              range_error;

   modport source (output valid, output red, output green, output blue,
                   output range_error, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input range_error, output ready);
endinterface

// File: design/hsvrgb_scale.sv
// Three-stage channel scaler: floor(255 * v * T / (12800 * 12800 * 3840)).
module hsvrgb_scale import hsvrgb_pkg::*; (
   input  logic                clock,
   input  hsvrgb_adv_type      adv,
   input  logic [PCT_W-1:0]    v,
   input  logic [T_W-1:0]      t,
   output logic [CHAN_W-1:0]   chan
);

   logic [Q_W-1:0]  q_in, q_ff;
   logic [QS_W-1:0] qs;
   logic [Y_W-1:0]  y_in, y_ff;
   logic [Z_W-1:0]  z_in, z_ff;

   // Multiply brightness by the channel weight
   assign q_in = Q_W'(v) * Q_W'(t);

   // Scale by 255 and drop the power-of-two part of the denominator
   assign qs   = {q_ff, {CHAN_W{1'b0}}} - QS_W'(q_ff);
   assign y_in = qs[QS_W-1:SCALE_SHIFT];

   // Divide by 9375 through a reciprocal multiply
   assign z_in = Z_W'(y_ff) * Z_W'(RECIP);

   always_ff @(posedge clock) begin
      if (adv.mul) begin
         q_ff <= q_in;
      end
      if (adv.scale) begin
         y_ff <= y_in;
      end
      if (adv.recip) begin
         z_ff <= z_in;
      end
   end

   // Quotient never exceeds 255 for in-range inputs
   assign chan = z_ff[RECIP_SHIFT +: CHAN_W];

endmodule

// File: design/hsv_to_rgb.sv
// HSV to RGB converter top level: eight-stage pipeline with valid/ready channels.
//
// Usage:
//   req_bus carries one HSV colour per request: hue (Q9.6 degrees), saturation
//   and brightness (Q7.7 percent). rsp_bus returns red, green and blue as the
//   floor of 255 times each fraction, plus range_error when hue exceeds 360.0
//   or saturation or brightness exceeds 100.0; the channels are then zero.
//   Both channels move an item at a clock edge where valid and ready are high.
//   A request taken on req_bus passes through eight register stages (input,
//   decode, products, weight subtract, three scaler stages, output) to rsp_bus.
//   Throughput: one request per cycle while rsp_bus.ready stays high.
//   Each stage advances when it is empty or the next stage advances, so a
//   bubble closes up and req_bus.ready stays high until all stages are full.
//   When rsp_bus.ready is low the output holds and the stages fill behind it;
//   nothing is dropped or repeated.
//   Reset (synchronous, active high) clears all valid bits; the pipeline is
//   empty and ready on the first cycle after reset.
`include "assert_macros.svh"

module hsv_to_rgb import hsvrgb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   hsvrgb_req_if.sink          req_bus,
   hsvrgb_rsp_if.source        rsp_bus
);

   logic [N_STAGES-1:0] vld_ff, vld_in;
   logic [N_STAGES-1:0] stage_adv;

   // Stage 0: input registers
   logic [HUE_W-1:0] hue_ff;
   logic [PCT_W-1:0] sat0_ff, val0_ff;

   // Stage 1: sector decode
   logic [SEC_W-1:0]  sec_in;
   logic [HUE_W-1:0]  base;
   logic [HUE_W-1:0]  frac_full;
   logic [FRAC_W-1:0] frac;
   logic [FRAC_W-1:0] umid_in, umid_ff;
   logic              err_in;
   logic [PCT_W-1:0]  sat1_ff, val1_ff;

   // Stage 2: products
   logic [T_W-1:0]   pmid_in, pmid_ff, pmin_in, pmin_ff;
   logic [PCT_W-1:0] val2_ff;

   // Stage 3: channel weights
   logic [T_W-1:0]   tmid_in, tmid_ff, tmin_in, tmin_ff;
   logic [PCT_W-1:0] val3_ff;

   // Sector and error travel with the data, stages 1 through 6
   logic [SEC_W-1:0] sec_ff [1:N_STAGES-2];
   logic             err_ff [1:N_STAGES-2];

   // Scaled channels at stage 6
   logic [CHAN_W-1:0] chan_max, chan_mid, chan_min;
   hsvrgb_adv_type    scale_adv;

   // Stage 7: output registers
   logic [CHAN_W-1:0] red_in, green_in, blue_in;
   logic [CHAN_W-1:0] red_ff, green_ff, blue_ff;
   logic              rerr_ff;

   // Terms of the checks at the end
   logic scaled_live, scaled_sorted, rsp_err, rsp_zero, req_take;

   // Advance a stage when it is empty or its successor advances
   always_comb begin
      stage_adv[N_STAGES-1] = !vld_ff[N_STAGES-1] || rsp_bus.ready;
      for (int i = N_STAGES - 2; i >= 0; i--) begin
         stage_adv[i] = !vld_ff[i] || stage_adv[i+1];
      end
   end

   always_comb begin
      vld_in[0] = stage_adv[0] ? req_bus.valid : vld_ff[0];
      for (int i = 1; i < N_STAGES; i++) begin
         vld_in[i] = stage_adv[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_bus.ready = stage_adv[0];

   // Find the 60-degree sector and the offset into it; hue 360 lands in the last
   always_comb begin
      if (hue_ff >= HUE_W'(5 * SECTOR_UNITS)) begin
         sec_in = SEC_MR;
         base   = HUE_W'(5 * SECTOR_UNITS);
      end else if (hue_ff >= HUE_W'(4 * SECTOR_UNITS)) begin
         sec_in = SEC_BM;
         base   = HUE_W'(4 * SECTOR_UNITS);
      end else if (hue_ff >= HUE_W'(3 * SECTOR_UNITS)) begin
         sec_in = SEC_CB;
         base   = HUE_W'(3 * SECTOR_UNITS);
      end else if (hue_ff >= HUE_W'(2 * SECTOR_UNITS)) begin
         sec_in = SEC_GC;
         base   = HUE_W'(2 * SECTOR_UNITS);
      end else if (hue_ff >= HUE_W'(SECTOR_UNITS)) begin
         sec_in = SEC_YG;
         base   = HUE_W'(SECTOR_UNITS);
      end else begin
         sec_in = SEC_RY;
         base   = '0;
      end
   end

   assign frac_full = hue_ff - base;
   assign frac      = frac_full[FRAC_W-1:0];

   // Rising sectors give X = C*f/3840, falling ones X = C*(3840-f)/3840;
   // keep u = 3840 - w so that the mid weight is 12800*3840 - s*u
   assign umid_in = (sec_in == SEC_YG || sec_in == SEC_CB || sec_in == SEC_MR)
                    ? frac : SECTOR_UNITS - frac;

   assign err_in = (hue_ff > HUE_MAX) || (sat0_ff > PCT_MAX) || (val0_ff > PCT_MAX);

   // Saturation products for the middle and smallest channels
   assign pmid_in = T_W'(sat1_ff) * T_W'(umid_ff);
   assign pmin_in = T_W'(sat1_ff) * T_W'(SECTOR_UNITS);

   // Channel weights
   assign tmid_in = T_FULL - pmid_ff;
   assign tmin_in = T_FULL - pmin_ff;

   always_ff @(posedge clock) begin
      if (stage_adv[0]) begin
         hue_ff  <= req_bus.hue;
         sat0_ff <= req_bus.saturation;
         val0_ff <= req_bus.brightness;
      end
      if (stage_adv[1]) begin
         umid_ff   <= umid_in;
         sat1_ff   <= sat0_ff;
         val1_ff   <= val0_ff;
         sec_ff[1] <= sec_in;
         err_ff[1] <= err_in;
      end
      if (stage_adv[2]) begin
         pmid_ff <= pmid_in;
         pmin_ff <= pmin_in;
         val2_ff <= val1_ff;
      end
      if (stage_adv[3]) begin
         tmid_ff <= tmid_in;
         tmin_ff <= tmin_in;
         val3_ff <= val2_ff;
      end
      for (int i = 2; i <= N_STAGES - 2; i++) begin
         if (stage_adv[i]) begin
            sec_ff[i] <= sec_ff[i-1];
            err_ff[i] <= err_ff[i-1];
         end
      end
   end

   // Scale the three channel weights in parallel
   assign scale_adv.mul   = stage_adv[4];
   assign scale_adv.scale = stage_adv[5];
   assign scale_adv.recip = stage_adv[6];

   hsvrgb_scale u_scale_max (
      .clock (clock),
      .adv   (scale_adv),
      .v     (val3_ff),
      .t     (T_FULL),
      .chan  (chan_max)
   );

   hsvrgb_scale u_scale_mid (
      .clock (clock),
      .adv   (scale_adv),
      .v     (val3_ff),
      .t     (tmid_ff),
      .chan  (chan_mid)
   );

   hsvrgb_scale u_scale_min (
      .clock (clock),
      .adv   (scale_adv),
      .v     (val3_ff),
      .t     (tmin_ff),
      .chan  (chan_min)
   );

   // Route the channels by sector; drop them on a range error
   always_comb begin
      case (sec_ff[N_STAGES-2])
         SEC_RY: begin
            red_in = chan_max; green_in = chan_mid; blue_in = chan_min;
         end
         SEC_YG: begin
            red_in = chan_mid; green_in = chan_max; blue_in = chan_min;
         end
         SEC_GC: begin
            red_in = chan_min; green_in = chan_max; blue_in = chan_mid;
         end
         SEC_CB: begin
            red_in = chan_min; green_in = chan_mid; blue_in = chan_max;
         end
         SEC_BM: begin
            red_in = chan_mid; green_in = chan_min; blue_in = chan_max;
         end
         default: begin
            red_in = chan_max; green_in = chan_min; blue_in = chan_mid;
         end
      endcase
      if (err_ff[N_STAGES-2]) begin
         red_in   = '0;
         green_in = '0;
         blue_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_adv[N_STAGES-1]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         rerr_ff  <= err_ff[N_STAGES-2];
      end
   end

   assign rsp_bus.valid       = vld_ff[N_STAGES-1];
   assign rsp_bus.red         = red_ff;
   assign rsp_bus.green       = green_ff;
   assign rsp_bus.blue        = blue_ff;
   assign rsp_bus.range_error = rerr_ff;

   // Build the check terms
   assign scaled_live   = vld_ff[N_STAGES-2] && !err_ff[N_STAGES-2];
   assign scaled_sorted = (chan_max >= chan_mid) && (chan_mid >= chan_min);
   assign rsp_err       = rsp_bus.valid && rsp_bus.range_error;
   assign rsp_zero      = (rsp_bus.red == '0) && (rsp_bus.green == '0) &&
                          (rsp_bus.blue == '0);
   assign req_take      = req_bus.valid && req_bus.ready;

   `ASSERT_CLK(a_chan_order, scaled_live |-> scaled_sorted, "scaled channels out of order")
   `ASSERT_CLK(a_err_zero, rsp_err |-> rsp_zero, "range error with nonzero channels")
   `ASSERT_CLK(a_req_load, req_take |=> vld_ff[0], "accepted request not loaded")
   `ASSERT_RST(a_reset_empty, reset |=> !rsp_bus.valid, "response valid after reset")

endmodule
